### design/linear_probe_hash_table_core_assert.svh
// assertion macros for the linear-probe hash table core
// used by the controller; no other dependencies
`ifndef LINEAR_PROBE_HASH_TABLE_CORE_ASSERT_SVH
`define LINEAR_PROBE_HASH_TABLE_CORE_ASSERT_SVH
`ifndef SYNTH
// plain property, sampled on the rising clock, off while reset is low
`define LPHT_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("lpht assertion failed");
// consequent checked in the cycle after the antecedent
`define LPHT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lpht assertion failed");
`else
`define LPHT_ASSERT(label, clk, rst_n, prop)
`define LPHT_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

### design/lpht_pkg.sv
// shared types and constants of the linear-probe hash table core
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package lpht_pkg;

    // default sizes
    localparam int TABLE_SLOTS_DEF = 1024;
    localparam int KEY_BITS_DEF    = 31;
    // table_size register value after reset
    localparam int TABLE_SIZE_RST  = 1024;

    // operation kind carried in the input tuser
    typedef enum logic {
        MODE_INSERT = 1'b0,
        MODE_SEARCH = 1'b1
    } t_mode;

    // result kind carried in the output tuser
    typedef enum logic [1:0] {
        ST_INSERTED  = 2'd0,
        ST_FULL      = 2'd1,
        ST_FOUND     = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    // controller to datapath
    typedef struct packed {
        logic clr_wr;    // clear one table entry
        logic load;      // capture an input transaction
        logic div_step;  // one remainder bit
        logic rd;        // read the probed slot
        logic chk;       // evaluate the probed slot
        logic out_load;  // move the result into the output register
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic clr_last;  // last entry of the clearing pass
        logic div_last;  // last remainder bit
        logic chk_stop;  // probe run finished
    } t_stat;

endpackage

`default_nettype wire

### design/linear_probe_hash_table_core.sv
// top level of the linear-probe hash table core
// depends on lpht_pkg, lpht_ctrl and lpht_dpath
//
// channel  direction  transaction                 payload
// s_axis   in         one insert or search        tdata: key, tuser: mode
// m_axis   out        one result per input        tdata: slot, tuser: status
// cfg      in         write of table_size         i_cfg_data: table_size
//
// per item: key mod table_size is formed one bit per cycle in the remainder unit,
//   and each probe is a read and a check of the table memory; a new input is
//   taken only once the previous result has moved to the output register
// reset: after i_rst_n the table is cleared one slot per cycle, all TABLE_SLOTS
//   slots, with s_axis_tready low; config writes are taken throughout
// stalls: a finished result waits in the output register while the next
//   transaction is accepted and worked on
`timescale 1ns / 1ps
`default_nettype none

module linear_probe_hash_table_core #(
    parameter int TABLE_SLOTS = lpht_pkg::TABLE_SLOTS_DEF,
    parameter int KEY_BITS    = lpht_pkg::KEY_BITS_DEF,
    localparam int SLOT_W     = $clog2(TABLE_SLOTS),
    localparam int CFG_W      = SLOT_W + 1,
    localparam int IN_DATA_W  = ((KEY_BITS + 7) / 8) * 8,
    localparam int OUT_DATA_W = ((SLOT_W + 7) / 8) * 8
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // input stream
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,   // key, zero padded
    input  wire logic [0:0]            s_axis_tuser,   // mode
    // result stream
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0]      m_axis_tdata,   // slot, zero padded
    output logic [1:0]                 m_axis_tuser,   // status
    // table_size write channel
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_W-1:0]      i_cfg_data
);

    lpht_pkg::t_cmd    cmd;
    lpht_pkg::t_stat   stat;
    lpht_pkg::t_status out_status;
    logic [SLOT_W-1:0] out_slot;

    // sequencing of clear, remainder and probe steps
    lpht_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .o_s_ready (s_axis_tready),
        .o_m_valid (m_axis_tvalid),
        .i_m_ready (m_axis_tready),
        .o_cmd     (cmd),
        .i_stat    (stat)
    );

    // table memory, remainder unit and result registers
    lpht_dpath #(
        .TABLE_SLOTS (TABLE_SLOTS),
        .KEY_BITS    (KEY_BITS)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_data   (i_cfg_data),
        .i_in_mode    (lpht_pkg::t_mode'(s_axis_tuser[0])),
        .i_in_key     (s_axis_tdata[KEY_BITS-1:0]),
        .o_out_status (out_status),
        .o_out_slot   (out_slot)
    );

    // writes must arrive only while idle, which the block does not enforce; the register is always open
    assign o_cfg_ready  = 1'b1;

    assign m_axis_tdata = OUT_DATA_W'(out_slot);
    assign m_axis_tuser = out_status;

endmodule

`default_nettype wire

### design/lpht_dpath.sv
// datapath: table memory, remainder unit, probe counters, result registers
// depends on lpht_pkg
`timescale 1ns / 1ps
`default_nettype none

module lpht_dpath #(
    parameter int TABLE_SLOTS = lpht_pkg::TABLE_SLOTS_DEF,
    parameter int KEY_BITS    = lpht_pkg::KEY_BITS_DEF,
    localparam int SLOT_W     = $clog2(TABLE_SLOTS),
    localparam int CFG_W      = SLOT_W + 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire lpht_pkg::t_cmd    i_cmd,
    output lpht_pkg::t_stat        o_stat,
    input  wire logic              i_cfg_valid,
    input  wire logic [CFG_W-1:0]  i_cfg_data,
    input  wire lpht_pkg::t_mode   i_in_mode,
    input  wire logic [KEY_BITS-1:0] i_in_key,
    output lpht_pkg::t_status      o_out_status,
    output logic [SLOT_W-1:0]      o_out_slot
);

    localparam int BIT_W = $clog2(KEY_BITS);
    localparam int RST_SIZE = (lpht_pkg::TABLE_SIZE_RST > TABLE_SLOTS) ?
                              TABLE_SLOTS : lpht_pkg::TABLE_SIZE_RST;

    // entry: occupied flag above the key
    logic [KEY_BITS:0] r_mem [TABLE_SLOTS];
    logic [KEY_BITS:0] r_rd;

    logic [CFG_W-1:0]    r_mod;
    logic [SLOT_W-1:0]   r_clr;
    logic [KEY_BITS-1:0] r_key;
    logic [KEY_BITS-1:0] r_key_sh;
    lpht_pkg::t_mode     r_mode;
    logic [CFG_W-1:0]    r_rem;
    logic [BIT_W-1:0]    r_bit;
    logic [SLOT_W-1:0]   r_j;
    logic [SLOT_W-1:0]   r_i;
    lpht_pkg::t_status   r_res_status;
    logic [SLOT_W-1:0]   r_res_slot;
    lpht_pkg::t_status   r_out_status;
    logic [SLOT_W-1:0]   r_out_slot;

    logic [CFG_W-1:0]    n_mod;
    logic [CFG_W-1:0]    rem_sh;
    logic [CFG_W-1:0]    n_rem;
    logic [CFG_W-1:0]    j_inc;
    logic [SLOT_W-1:0]   j_next;
    logic                probe_last;
    logic                slot_free;
    logic                key_eq;
    logic                chk_stop;
    lpht_pkg::t_status   chk_status;
    logic                ins_wr;

    // clamp of the size register to 1 .. TABLE_SLOTS
    always_comb begin
        priority if (i_cfg_data == '0) begin
            n_mod = CFG_W'(1);
        end else if (i_cfg_data > CFG_W'(TABLE_SLOTS)) begin
            n_mod = CFG_W'(TABLE_SLOTS);
        end else begin
            n_mod = i_cfg_data;
        end
    end

    // restoring remainder, msb first
    always_comb begin
        rem_sh = {r_rem[CFG_W-2:0], r_key_sh[KEY_BITS-1]};
        n_rem  = (rem_sh >= r_mod) ? (rem_sh - r_mod) : rem_sh;
    end

    always_comb begin
        j_inc      = {1'b0, r_j} + CFG_W'(1);
        j_next     = (j_inc == r_mod) ? '0 : j_inc[SLOT_W-1:0];
        probe_last = ({1'b0, r_i} == (r_mod - CFG_W'(1)));
        slot_free  = !r_rd[KEY_BITS];
        key_eq     = (r_rd[KEY_BITS-1:0] == r_key);
    end

    always_comb begin
        chk_stop   = 1'b0;
        chk_status = lpht_pkg::ST_NOT_FOUND;
        if (r_mode == lpht_pkg::MODE_INSERT) begin
            priority if (slot_free) begin
                chk_stop   = 1'b1;
                chk_status = lpht_pkg::ST_INSERTED;
            end else if (probe_last) begin
                chk_stop   = 1'b1;
                chk_status = lpht_pkg::ST_FULL;
            end else begin
                chk_stop   = 1'b0;
            end
        end else begin
            priority if (slot_free) begin
                chk_stop   = 1'b1;
                chk_status = lpht_pkg::ST_NOT_FOUND;
            end else if (key_eq) begin
                chk_stop   = 1'b1;
                chk_status = lpht_pkg::ST_FOUND;
            end else if (probe_last) begin
                chk_stop   = 1'b1;
                chk_status = lpht_pkg::ST_NOT_FOUND;
            end else begin
                chk_stop   = 1'b0;
            end
        end
    end

    assign ins_wr = i_cmd.chk && chk_stop && (chk_status == lpht_pkg::ST_INSERTED);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mod <= CFG_W'(RST_SIZE);
            r_clr <= '0;
            r_bit <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_mod <= n_mod;
            end
            if (i_cmd.clr_wr) begin
                r_clr <= r_clr + SLOT_W'(1);
            end
            if (i_cmd.load) begin
                r_bit <= '0;
            end else if (i_cmd.div_step) begin
                r_bit <= r_bit + BIT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_key    <= i_in_key;
            r_key_sh <= i_in_key;
            r_mode   <= i_in_mode;
            r_rem    <= '0;
        end else if (i_cmd.div_step) begin
            r_key_sh <= {r_key_sh[KEY_BITS-2:0], 1'b0};
            r_rem    <= n_rem;
        end
        if (i_cmd.div_step && o_stat.div_last) begin
            r_j <= n_rem[SLOT_W-1:0];
            r_i <= '0;
        end else if (i_cmd.chk && !chk_stop) begin
            r_j <= j_next;
            r_i <= r_i + SLOT_W'(1);
        end
        if (i_cmd.chk && chk_stop) begin
            r_res_status <= chk_status;
            r_res_slot   <= ((chk_status == lpht_pkg::ST_INSERTED) ||
                             (chk_status == lpht_pkg::ST_FOUND)) ? r_j : '0;
        end
        if (i_cmd.out_load) begin
            r_out_status <= r_res_status;
            r_out_slot   <= r_res_slot;
        end
    end

    // table memory, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_wr) begin
            r_mem[r_clr] <= '0;
        end else if (ins_wr) begin
            r_mem[r_j] <= {1'b1, r_key};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_rd <= r_mem[r_j];
        end
    end

    assign o_stat.clr_last = (r_clr == SLOT_W'(TABLE_SLOTS - 1));
    assign o_stat.div_last = (r_bit == BIT_W'(KEY_BITS - 1));
    assign o_stat.chk_stop = chk_stop;

    assign o_out_status = r_out_status;
    assign o_out_slot   = r_out_slot;

endmodule

`default_nettype wire

### design/lpht_ctrl.sv
// controller state machine of the linear-probe hash table core
// depends on lpht_pkg and linear_probe_hash_table_core_assert.svh
`timescale 1ns / 1ps
`default_nettype none
`include "linear_probe_hash_table_core_assert.svh"

module lpht_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_s_valid,
    output logic                  o_s_ready,
    output logic                  o_m_valid,
    input  wire logic             i_m_ready,
    output lpht_pkg::t_cmd        o_cmd,
    input  wire lpht_pkg::t_stat  i_stat
);

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_DIV   = 6'b000100,
        S_RD    = 6'b001000,
        S_CHK   = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_m_valid;
    logic   n_m_valid;
    logic   out_free;

    assign out_free = !r_m_valid || i_m_ready;

    always_comb begin
        n_state   = r_state;
        o_cmd     = '0;
        o_s_ready = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_s_ready = 1'b1;
                if (i_s_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_last) begin
                    n_state = S_RD;
                end
            end
            S_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = S_CHK;
            end
            S_CHK: begin
                o_cmd.chk = 1'b1;
                n_state   = i_stat.chk_stop ? S_DONE : S_RD;
            end
            S_DONE: begin
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_comb begin
        priority if (o_cmd.out_load) begin
            n_m_valid = 1'b1;
        end else if (i_m_ready) begin
            n_m_valid = 1'b0;
        end else begin
            n_m_valid = r_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_m_valid <= n_m_valid;
        end
    end

    assign o_m_valid = r_m_valid;

    // a taken input closes the input side at once
    `LPHT_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_s_valid && o_s_ready, !o_s_ready)
    // a result never overwrites one still waiting
    `LPHT_ASSERT(a_no_overwrite, i_clk, i_rst_n, o_cmd.out_load |-> out_free)
    // every read is followed by its check
    `LPHT_ASSERT_NEXT(a_rd_then_chk, i_clk, i_rst_n, r_state == S_RD, r_state == S_CHK)
    // output valid only rises out of the done state
    `LPHT_ASSERT(a_valid_from_done, i_clk, i_rst_n, $rose(r_m_valid) |-> $past(r_state == S_DONE))

endmodule

`default_nettype wire

### bench/tb.sv
// self-checking bench for linear_probe_hash_table_core: inserts and searches against a
// local copy of the probed table, checked result by result; depends on lpht_pkg and the core
`timescale 1ns / 1ps

module tb;

    localparam int SLOTS       = lpht_pkg::TABLE_SLOTS_DEF;
    localparam int KEY_W       = lpht_pkg::KEY_BITS_DEF;
    localparam int SLOT_W      = $clog2(SLOTS);
    localparam int SIZE_W      = SLOT_W + 1;
    localparam int OUT_W       = ((SLOT_W + 7) / 8) * 8;
    localparam int HOLD_CYCLES = 600;
    // clearing pass plus every item probing the whole table behind the longest stalls
    localparam int RUN_LIMIT   = 4 * (1400 * (KEY_W + 2 + 2 * SLOTS + 34) + SLOTS + HOLD_CYCLES);

    typedef struct packed {
        lpht_pkg::t_mode  mode;
        logic [KEY_W-1:0] key;
    } t_probe_req;

    typedef struct packed {
        lpht_pkg::t_status status;
        logic [SLOT_W-1:0] slot;
    } t_probe_outcome;

    logic                i_clk         = 1'b0;
    logic                i_rst_n       = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [31:0]         s_axis_tdata  = '0;   // key, padding bit
    logic [0:0]          s_axis_tuser  = '0;   // mode
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [OUT_W-1:0]    m_axis_tdata;         // slot, padding
    logic [1:0]          m_axis_tuser;         // status
    logic                i_cfg_valid   = 1'b0;
    logic                o_cfg_ready;
    logic [SIZE_W-1:0]   i_cfg_data    = '0;

    // local copy of the table and its size register
    logic [KEY_W-1:0]    table_keys [SLOTS];
    bit                  table_used [SLOTS];
    logic [SIZE_W-1:0]   table_size_reg = SIZE_W'(lpht_pkg::TABLE_SIZE_RST);

    t_probe_req          probe_queue[$];
    t_probe_outcome      predicted_outcomes[$];
    logic [KEY_W-1:0]    inserted_keys[$];

    int                  items_queued   = 0;
    int                  items_sent     = 0;
    int                  error_count    = 0;
    int                  size_settings  = 1;
    int                  status_count [4] = '{0, 0, 0, 0};
    int                  cycle_count    = 0;
    bit                  in_taken       = 1'b0;
    bit                  out_taken      = 1'b0;
    bit                  idle_on        = 1'b1;
    bit                  hold_arm       = 1'b0;
    bit                  hold_used      = 1'b0;
    int                  tx_gap         = 0;
    int                  rx_wait        = 0;
    int                  rx_hold        = 0;
    t_probe_req          tx_req;
    t_probe_outcome      got_outcome;
    t_probe_outcome      exp_outcome;

    linear_probe_hash_table_core DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // size 0 probes like 1, anything above the slot count like the slot count
    function automatic int unsigned probe_span(input logic [SIZE_W-1:0] size);
        if (size == 0) return 1;
        if (size > SLOTS) return SLOTS;
        return size;
    endfunction

    // walk (key + i) mod span, updating the local table on a successful insert
    function automatic t_probe_outcome probe_table(input t_probe_req req);
        t_probe_outcome res;
        int unsigned    span;
        int unsigned    base;
        int unsigned    idx;
        int unsigned    i;
        bit             done;
        span       = probe_span(table_size_reg);
        base       = req.key % span;
        res.slot   = '0;
        res.status = (req.mode == lpht_pkg::MODE_INSERT) ? lpht_pkg::ST_FULL :
                                                           lpht_pkg::ST_NOT_FOUND;
        done       = 1'b0;
        for (i = 0; i < span && !done; i++) begin
            idx = (base + i) % span;
            if (req.mode == lpht_pkg::MODE_INSERT) begin
                if (!table_used[idx]) begin
                    table_used[idx] = 1'b1;
                    table_keys[idx] = req.key;
                    res.status      = lpht_pkg::ST_INSERTED;
                    res.slot        = SLOT_W'(idx);
                    done            = 1'b1;
                end
            end else if (!table_used[idx]) begin
                done = 1'b1;
            end else if (table_keys[idx] == req.key) begin
                res.status = lpht_pkg::ST_FOUND;
                res.slot   = SLOT_W'(idx);
                done       = 1'b1;
            end
        end
        return res;
    endfunction

    // sender: one transaction per queued request, random gap after each while idle_on is set
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (s_axis_tvalid && !in_taken) begin
            // offered transaction still waiting for tready
        end else if (tx_gap != 0) begin
            tx_gap = tx_gap - 1;
            s_axis_tvalid <= 1'b0;
        end else if (probe_queue.size() != 0) begin
            tx_req = probe_queue.pop_front();
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= {1'b0, tx_req.key};
            s_axis_tuser  <= tx_req.mode;
            tx_gap = idle_on ? $urandom_range(0, 16) : 0;
        end else begin
            s_axis_tvalid <= 1'b0;
        end
    end

    // receiver: random stall after each result while idle_on is set, one long hold-off when armed
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (out_taken)
                rx_wait = idle_on ? $urandom_range(0, 16) : 0;
            if (hold_arm && !hold_used) begin
                rx_hold   = HOLD_CYCLES;
                hold_used = 1'b1;
            end
            if (rx_hold != 0) begin
                rx_hold = rx_hold - 1;
                m_axis_tready <= 1'b0;
            end else if (rx_wait != 0) begin
                rx_wait = rx_wait - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // monitor: check results first, then predict the transaction taken at this edge
    always @(posedge i_clk) begin
        in_taken  = i_rst_n && s_axis_tvalid && s_axis_tready;
        out_taken = i_rst_n && m_axis_tvalid && m_axis_tready;
        if (out_taken) begin
            got_outcome.status = lpht_pkg::t_status'(m_axis_tuser);
            got_outcome.slot   = m_axis_tdata[SLOT_W-1:0];
            if (predicted_outcomes.size() == 0) begin
                $display("%0t: result with nothing expected, status %0d slot %0d",
                         $time, m_axis_tuser, m_axis_tdata);
                error_count++;
            end else begin
                exp_outcome = predicted_outcomes.pop_front();
                status_count[exp_outcome.status]++;
                if (got_outcome.status != exp_outcome.status) begin
                    $display("%0t: status mismatch, expected %0d got %0d",
                             $time, exp_outcome.status, got_outcome.status);
                    error_count++;
                end
                if (m_axis_tdata != OUT_W'(exp_outcome.slot)) begin
                    $display("%0t: slot mismatch, expected %0d got %0d",
                             $time, exp_outcome.slot, m_axis_tdata);
                    error_count++;
                end
            end
        end
        if (in_taken) begin
            items_sent++;
            predicted_outcomes.push_back(
                probe_table('{mode: lpht_pkg::t_mode'(s_axis_tuser[0]),
                              key: s_axis_tdata[KEY_W-1:0]}));
        end
    end

    initial begin
        while (cycle_count < RUN_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("%0t: no completion within %0d cycles", $time, RUN_LIMIT);
        $display("TB_ERROR");
        $finish;
    end

    function automatic void queue_probe(input lpht_pkg::t_mode mode,
                                        input logic [KEY_W-1:0] key);
        probe_queue.push_back('{mode: mode, key: key});
        items_queued++;
        if (mode == lpht_pkg::MODE_INSERT)
            inserted_keys.push_back(key);
    endfunction

    // every request sent and every result back
    task automatic wait_idle();
        while (items_sent != items_queued || predicted_outcomes.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic write_table_size(input logic [SIZE_W-1:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        table_size_reg = value;
        size_settings++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // one table size, random inserts and searches; searches often reuse stored keys
    task automatic run_phase(input logic [SIZE_W-1:0] size, input int count, input bit idle);
        int unsigned      span;
        int               n;
        int unsigned      sel;
        lpht_pkg::t_mode  mode;
        logic [KEY_W-1:0] key;
        write_table_size(size);
        idle_on = idle;
        span    = probe_span(size);
        for (n = 0; n < count; n++) begin
            mode = ($urandom_range(0, 99) < 55) ? lpht_pkg::MODE_INSERT :
                                                  lpht_pkg::MODE_SEARCH;
            sel  = $urandom_range(0, 9);
            if (mode == lpht_pkg::MODE_SEARCH && sel < 5 && inserted_keys.size() != 0)
                key = inserted_keys[$urandom_range(0, inserted_keys.size() - 1)];
            else if (sel < 7)
                key = KEY_W'($urandom_range(0, 2 * span + 3));
            else if (sel < 9)
                key = KEY_W'($urandom);
            else
                key = {KEY_W{1'b1}} - KEY_W'($urandom_range(0, 255));
            queue_probe(mode, key);
        end
        wait_idle();
    endtask

    initial begin
        // directed: empty table, both key extremes, wrap-around, duplicates, misses
        queue_probe(lpht_pkg::MODE_SEARCH, 31'd5);
        queue_probe(lpht_pkg::MODE_INSERT, 31'd0);
        queue_probe(lpht_pkg::MODE_INSERT, 31'h7FFF_FFFF);
        queue_probe(lpht_pkg::MODE_INSERT, 31'd1023);  // wraps from the top slot to slot 1
        queue_probe(lpht_pkg::MODE_INSERT, 31'd0);     // duplicate takes another slot
        queue_probe(lpht_pkg::MODE_SEARCH, 31'd0);
        queue_probe(lpht_pkg::MODE_SEARCH, 31'd1023);
        queue_probe(lpht_pkg::MODE_SEARCH, 31'd2047);  // runs past the cluster, misses
        queue_probe(lpht_pkg::MODE_INSERT, 31'd1024);
        queue_probe(lpht_pkg::MODE_SEARCH, 31'd1024);
        queue_probe(lpht_pkg::MODE_INSERT, 31'h4000_0000);
        queue_probe(lpht_pkg::MODE_SEARCH, 31'h7FFF_FFFF);
        queue_probe(lpht_pkg::MODE_INSERT, 31'h2AAA_AAAA);
        queue_probe(lpht_pkg::MODE_INSERT, 31'h5555_5555);
        queue_probe(lpht_pkg::MODE_SEARCH, 31'h5555_5555);
        queue_probe(lpht_pkg::MODE_SEARCH, 31'h2AAA_AAAB);
        queue_probe(lpht_pkg::MODE_SEARCH, 31'h7FFF_FFFE);
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        wait_idle();

        run_phase(11'd0,    40,  1'b1);               // zero acts as one slot
        run_phase(11'd1,    40,  1'b0);
        run_phase(11'd5,    80,  1'b1);
        run_phase(11'd37,   150, 1'b1);
        run_phase(11'd2047, 200, 1'b0);               // oversize acts as the full table
        hold_arm = 1'b1;                              // long output hold-off, sender keeps going
        run_phase(11'd128,  150, 1'b0);
        run_phase(11'd1000, 250, 1'b1);
        run_phase(11'd1024, 250, 1'b0);
        run_phase(11'd7,    60,  1'b1);
        run_phase(11'd1536, 110, 1'b1);

        repeat (2 * (KEY_W + 8)) @(posedge i_clk);
        $display("covered %0d inserts and searches over %0d table_size settings",
                 items_sent, size_settings);
        $display("results: %0d inserted, %0d full, %0d found, %0d not found",
                 status_count[lpht_pkg::ST_INSERTED], status_count[lpht_pkg::ST_FULL],
                 status_count[lpht_pkg::ST_FOUND], status_count[lpht_pkg::ST_NOT_FOUND]);
        if (error_count == 0 && predicted_outcomes.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

### files.f
+incdir+design
design/lpht_pkg.sv
design/lpht_dpath.sv
design/lpht_ctrl.sv
design/linear_probe_hash_table_core.sv
bench/tb.sv
